@@ rtl/hs1_pkg.sv @@
// shared types, constants and functions for the hmac-sha1 engine
`default_nettype none
package hs1_pkg;

	localparam int NUM_KEY_REGS = 8;
	localparam int KEY_REG_W    = 64;
	localparam int KEY_IDX_W    = 3;
	localparam int WORD_W       = 32;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] IPAD_WORD = 32'h36363636;
	localparam logic [31:0] OPAD_WORD = 32'h5C5C5C5C;
	localparam logic [7:0]  PAD_BYTE  = 8'h80;
	localparam logic [63:0] OUTER_BITS = 64'd672;
	localparam logic [63:0] KEY_BITS   = 64'd512;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY_LOAD,
		ST_KEY_RUN,
		ST_BYTE,
		ST_PAD_80,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_OUTER_KEY,
		ST_OUTER_RUN,
		ST_EMIT
	} hs1_state_t;

	// control from sequencer to round unit
	typedef struct packed {
		logic        start;   // copy chain into work vars, begin 80 rounds
		logic        init_iv; // load chain with initial values
		logic        write_en;
		logic [3:0]  write_idx;
		logic [31:0] write_word;
	} hs1_ctl_t;

	// status from round unit
	typedef struct packed {
		logic busy;
	} hs1_sts_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/hs1_round.sv @@
// sha-1 compression: one round per cycle over a 16-word block buffer
`default_nettype none
module hs1_round (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hs1_pkg::hs1_ctl_t ctl,
	output hs1_pkg::hs1_sts_t      sts,
	output logic [31:0]            chain [5]
);
	import hs1_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        busy_q;

	logic [31:0] w_cur, w_new, f, k, tmp;
	logic [3:0]  widx;

	// message schedule word for this round
	always_comb begin
		widx  = rnd_q[3:0];
		w_new = rotl1(w_q[4'(widx - 4'd3)] ^ w_q[4'(widx - 4'd8)] ^
			w_q[4'(widx - 4'd14)] ^ w_q[widx]);
		w_cur = (rnd_q < 7'd16) ? w_q[widx] : w_new;
	end

	// round function and constant
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
	end

	// control: round counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 7'd1;
			if (rnd_q == 7'd79)
				busy_q <= 1'b0;
		end
	end

	// chain hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '{IV0, IV1, IV2, IV3, IV4};
		end else if (ctl.init_iv) begin
			h_q <= '{IV0, IV1, IV2, IV3, IV4};
		end else if (busy_q && rnd_q == 7'd79) begin
			h_q[0] <= h_q[0] + tmp;
			h_q[1] <= h_q[1] + a_q;
			h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
			h_q[3] <= h_q[3] + c_q;
			h_q[4] <= h_q[4] + d_q;
		end
	end

	// working variables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{a_q, b_q, c_q, d_q, e_q} <= '0;
		end else if (ctl.start) begin
			{a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		end else if (busy_q) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= tmp;
		end
	end

	// block buffer: loaded by the sequencer, rewritten by the schedule
	always_ff @(posedge clk) begin
		if (ctl.write_en)
			w_q[ctl.write_idx] <= ctl.write_word;
		else if (busy_q && rnd_q >= 7'd16)
			w_q[widx] <= w_new;
	end

	assign sts.busy = busy_q;
	assign chain    = h_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("start while busy");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.write_en) else $error("block write while busy");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rnd_q <= 7'd79) else $error("round out of range");

endmodule
`default_nettype wire

@@ rtl/hmac_sha1_engine.sv @@
// top level: hmac-sha1 sequencer, key registers and output word select
//
// channel  | direction | handshake        | payload
// cfg      | in        | cfg_we           | cfg_idx, cfg_data
// in       | in        | in_valid/ready   | data_byte, byte_valid, message_end
// out      | out       | out_valid/ready  | digest_word, last_word
//
// a data byte is merged into the block buffer and, when it closes a 64-byte block,
// starts a compression; the first item of a message first loads and runs the inner
// key block. the end marker runs padding (1 to 2 blocks, one pad byte per cycle
// while the round unit is idle) and the outer pass (the outer key block, then 5 word
// writes, 44 pad bytes and a compression); all passes share the one round unit.
// five digest items leave in order; the output stall holds the sequencer.
// asynchronous reset returns to the idle state with zero keys and no key block run.
`default_nettype none
module hmac_sha1_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        message_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic             last_word
);
	import hs1_pkg::*;

	hs1_state_t  state_q, state_d;
	hs1_ctl_t    ctl;
	hs1_sts_t    sts;
	logic [31:0] chain [5];

	logic [63:0] key_q [NUM_KEY_REGS];
	logic [63:0] bits_q, bits_d;
	logic [5:0]  pos_q, pos_d;
	logic        kdone_q, kdone_d;
	logic        outer_q, outer_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        end_q, end_d;
	logic [7:0]  byte_q, byte_d;
	logic [31:0] part_q, part_d;
	logic [31:0] inner_q [5];
	logic        cap_inner;
	logic [2:0]  oidx_q, oidx_d;
	logic        bv_q;

	logic [7:0]  pb;
	logic [63:0] len;
	logic [31:0] kw, merged;

	hs1_round u_round (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sts   (sts),
		.chain (chain)
	);

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			for (int i = 0; i < NUM_KEY_REGS; i++) key_q[i] <= '0;
		else if (cfg_we)
			key_q[cfg_idx] <= cfg_data;
	end

	// key word for the current block slot, length source and byte merge
	always_comb begin
		kw = cnt_q[0] ? key_q[cnt_q[3:1]][31:0] : key_q[cnt_q[3:1]][63:32];
		len = outer_q ? OUTER_BITS : bits_q;
		merged = part_q;
		unique case (pos_q[1:0])
			2'd0: merged[31:24] = pb;
			2'd1: merged[23:16] = pb;
			2'd2: merged[15:8]  = pb;
			default: merged[7:0] = pb;
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q  <= '0;
			pos_q   <= '0;
			kdone_q <= 1'b0;
			outer_q <= 1'b0;
			cnt_q   <= '0;
			end_q   <= 1'b0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			bits_q  <= bits_d;
			pos_q   <= pos_d;
			kdone_q <= kdone_d;
			outer_q <= outer_d;
			cnt_q   <= cnt_d;
			end_q   <= end_d;
			oidx_q  <= oidx_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		part_q <= part_d;
		if (cap_inner) inner_q <= chain;
	end

	// remember whether the pending item carries a byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bv_q <= 1'b0;
		else if (in_valid && in_ready) bv_q <= byte_valid;
	end

	// next state and round unit control
	always_comb begin
		state_d   = state_q;
		bits_d    = bits_q;
		pos_d     = pos_q;
		kdone_d   = kdone_q;
		outer_d   = outer_q;
		cnt_d     = cnt_q;
		end_d     = end_q;
		oidx_d    = oidx_q;
		byte_d    = byte_q;
		part_d    = part_q;
		cap_inner = 1'b0;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		pb        = byte_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !sts.busy;
				if (in_valid && in_ready && (byte_valid || message_end)) begin
					byte_d = data_byte;
					end_d  = message_end;
					if (!kdone_q) begin
						ctl.init_iv = 1'b1;
						cnt_d   = '0;
						state_d = ST_KEY_LOAD;
					end else if (byte_valid) begin
						state_d = ST_BYTE;
					end else begin
						state_d = ST_PAD_80;
					end
					if (byte_valid) bits_d = bits_q + 64'd8;
				end
			end
			ST_KEY_LOAD, ST_OUTER_KEY: begin
				if (!sts.busy) begin
					ctl.write_en   = 1'b1;
					ctl.write_idx  = cnt_q;
					ctl.write_word = kw ^ ((state_q == ST_OUTER_KEY) ? OPAD_WORD : IPAD_WORD);
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						ctl.start = 1'b1;
						state_d = (state_q == ST_OUTER_KEY) ? ST_OUTER_RUN : ST_KEY_RUN;
					end
				end
			end
			ST_KEY_RUN: begin
				if (!sts.busy) begin
					kdone_d = 1'b1;
					pos_d   = '0;
					bits_d  = bits_q + KEY_BITS;
					state_d = bv_q ? ST_BYTE : ST_PAD_80;
				end
			end
			ST_OUTER_RUN: begin
				if (!sts.busy) begin
					cnt_d   = '0;
					pos_d   = 6'd20;
					state_d = ST_PAD_80;
				end
			end
			ST_BYTE, ST_PAD_80, ST_PAD_ZERO, ST_PAD_LEN: begin
				if (!sts.busy) begin
					// inner digest words go in after the outer key block
					if (outer_q && cnt_q < 4'd5 && state_q == ST_PAD_80) begin
						ctl.write_en   = 1'b1;
						ctl.write_idx  = cnt_q;
						ctl.write_word = inner_q[cnt_q[2:0]];
						cnt_d = cnt_q + 4'd1;
					end else begin
						unique case (state_q)
							ST_BYTE:     pb = byte_q;
							ST_PAD_80:   pb = PAD_BYTE;
							ST_PAD_ZERO: pb = 8'h00;
							default:     pb = len[6'(6'd56 - {cnt_q[2:0], 3'd0}) +: 8];
						endcase
						part_d = merged;
						if (pos_q[1:0] == 2'd3) begin
							ctl.write_en   = 1'b1;
							ctl.write_idx  = pos_q[5:2];
							ctl.write_word = merged;
						end
						pos_d = pos_q + 6'd1;
						if (pos_q == 6'd63) ctl.start = 1'b1;
						unique case (state_q)
							ST_BYTE: state_d = end_q ? ST_PAD_80 : ST_IDLE;
							ST_PAD_80: begin
								state_d = (pos_q + 6'd1 == 6'd56) ? ST_PAD_LEN : ST_PAD_ZERO;
								cnt_d = '0;
							end
							ST_PAD_ZERO: state_d = (pos_q + 6'd1 == 6'd56) ? ST_PAD_LEN
								: ST_PAD_ZERO;
							default: begin
								cnt_d = cnt_q + 4'd1;
								if (cnt_q == 4'd7) state_d = outer_q ? ST_EMIT : ST_OUTER_KEY;
							end
						endcase
						if (state_q == ST_PAD_LEN && cnt_q == 4'd7 && !outer_q) begin
							cnt_d = '0;
							outer_d = 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				out_valid = !sts.busy;
				if (out_valid && out_ready) begin
					oidx_d = oidx_q + 3'd1;
					if (oidx_q == 3'd4) begin
						oidx_d  = '0;
						state_d = ST_IDLE;
						kdone_d = 1'b0;
						outer_d = 1'b0;
						bits_d  = '0;
						pos_d   = '0;
						ctl.init_iv = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// capture inner digest and reload iv when outer key block starts
		if (state_q == ST_OUTER_KEY && cnt_q == 4'd0 && !sts.busy) begin
			cap_inner   = 1'b1;
			ctl.init_iv = 1'b1;
		end
	end

	assign digest_word = chain[oidx_q];
	assign last_word   = (oidx_q == 3'd4);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_emit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("output and input at once");
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> state_q == ST_IDLE)
		else $error("no return to idle after last word");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the hmac-sha1 engine
`default_nettype none
module tb;
	import hs1_pkg::*;

	localparam int LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        byte_valid = 1'b0;
	logic        message_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic        last_word;

	// digest word plus last flag
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_item_t;

	digest_item_t digest_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// predictor state
	logic [63:0] key_shadow[8];
	logic [31:0] hh[5];
	logic [31:0] blk[16];
	logic [63:0] msg_bits;
	int          fill;
	bit          armed_key;

	hmac_sha1_engine i_dut (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] rl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one sha-1 compression of blk into hh
	task automatic sha_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 80; i++) w[i] = rl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hh[0]; b = hh[1]; c = hh[2]; d = hh[3]; e = hh[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rl(b, 30); b = a; a = t;
		end
		hh[0] += a; hh[1] += b; hh[2] += c; hh[3] += d; hh[4] += e;
	endtask

	task automatic load_iv();
		hh[0] = IV0; hh[1] = IV1; hh[2] = IV2; hh[3] = IV3; hh[4] = IV4;
	endtask

	task automatic key_block(input logic [31:0] pad);
		for (int i = 0; i < 16; i++)
			blk[i] = (i % 2 ? key_shadow[i/2][31:0] : key_shadow[i/2][63:32]) ^ pad;
		sha_block();
	endtask

	task automatic push_byte(input logic [7:0] b);
		blk[fill/4][(3 - fill%4)*8 +: 8] = b;
		fill++;
		if (fill == 64) begin
			sha_block();
			fill = 0;
		end
	endtask

	task automatic close_pad(input logic [63:0] len);
		push_byte(PAD_BYTE);
		while (fill != 56) push_byte(8'h00);
		for (int i = 0; i < 8; i++) push_byte(len[56 - 8*i +: 8]);
	endtask

	// work out the digest words an accepted item causes
	task automatic predict_hmac(input logic [7:0] db, input logic bv, input logic me);
		logic [31:0] inner[5];
		digest_item_t it;
		if (!bv && !me) return;
		if (!armed_key) begin
			load_iv();
			key_block(IPAD_WORD);
			msg_bits = KEY_BITS;
			fill = 0;
			armed_key = 1;
		end
		if (bv) begin
			push_byte(db);
			msg_bits += 64'd8;
		end
		if (!me) return;
		close_pad(msg_bits);
		inner = hh;
		load_iv();
		key_block(OPAD_WORD);
		for (int i = 0; i < 5; i++) blk[i] = inner[i];
		fill = 20;
		close_pad(OUTER_BITS);
		for (int i = 0; i < 5; i++) begin
			it.word = hh[i];
			it.last = (i == 4);
			digest_q.push_back(it);
		end
		armed_key = 0;
		fill = 0;
		msg_bits = '0;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	// cycle limit and receiver stall
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		digest_item_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				report("unexpected item", digest_word, '0);
			end else begin
				exp = digest_q.pop_front();
				if (digest_word !== exp.word) report("digest_word", digest_word, exp.word);
				if (last_word !== exp.last) report("last_word", last_word, exp.last);
			end
		end
	end

	// send one item, waiting for acceptance; valid stays up until the next item
	task automatic send_item(input logic [7:0] db, input logic bv, input logic me);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= db;
		byte_valid <= bv;
		message_end <= me;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		predict_hmac(db, bv, me);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_key(input int idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx[2:0];
		cfg_data <= val;
		@(posedge clk);
		key_shadow[idx] = val;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
		send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic test_directed();
		// empty message with zero key
		send_item(8'h00, 1'b0, 1'b1);
		// idle items give nothing
		send_item(8'hff, 1'b0, 1'b0);
		// extremes, byte on end marker
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);
		drain();
		for (int i = 0; i < 8; i++) write_key(i, '1);
		cfg_we <= 1'b0;
		send_item(8'h5a, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		drain();
	endtask

	// messages around block boundaries and padding splits
	task automatic test_block_edges(input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < 8; i++) write_key(i, {$urandom, $urandom});
		cfg_we <= 1'b0;
		send_message(56);
		send_message(64);
		drain();
	endtask

	task automatic test_random(input int idle, input int stall, input int n);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < 8; i++)
			write_key(i, ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom});
		cfg_we <= 1'b0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				1, 2: send_item(8'($urandom_range(255)), 1'b1, 1'b1);
				3: send_item(8'($urandom_range(255)), 1'b0, 1'b1);
				default: send_item(8'($urandom_range(255)), 1'b1, 1'b0);
			endcase
		end
		send_item(8'h00, 1'b0, 1'b1);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) key_shadow[i] = '0;
		armed_key = 0;
		fill = 0;
		msg_bits = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_edges(0, 0);
		test_random(0, 0, 12);
		test_random(58, 0, 12);
		test_random(0, 58, 12);
		test_random(32, 32, 12);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/hs1_pkg.sv
rtl/hs1_round.sv
rtl/hmac_sha1_engine.sv
tb/tb.sv
